// ----- design/csl_pkg.sv -----
package csl_pkg;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_RX      = 2'd1,
		CMD_READ    = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_META,
		ST_RESP
	} seq_state_t;

	typedef enum logic [1:0] {
		REG_SCAN_ENABLE     = 2'd0,
		REG_STATION_CHANNEL = 2'd1,
		REG_DWELL_TICKS     = 2'd2,
		REG_PING_TICKS      = 2'd3
	} reg_idx_t;

	localparam logic [3:0]  CH_LOW      = 4'd1;
	localparam logic [3:0]  CH_HIGH     = 4'd13;
	localparam logic [7:0]  PING_MARK   = 8'h80;
	localparam logic [7:0]  CH_MASK     = 8'h0F;
	localparam logic [15:0] DWELL_RESET = 16'd500;
	localparam logic [15:0] PING_RESET  = 16'd1000;
	localparam logic [7:0]  RSSI_RESET  = 8'h81;
	localparam logic [15:0] SAT16       = 16'hFFFF;

	typedef struct packed {
		logic        tick;
		logic        restart;
		logic        scan_enable;
		logic [3:0]  station_channel;
		logic [15:0] dwell_ticks;
		logic [15:0] ping_ticks;
		logic        lock_req;
		logic [3:0]  lock_channel;
	} link_ctl_t;

	typedef struct packed {
		logic [3:0] channel;
		logic       scanning;
		logic       ping_send;
		logic [7:0] ping_value;
		logic       locked_event;
	} link_stat_t;

	function automatic logic [3:0] clamp_channel(input logic [3:0] c);
		if (c < CH_LOW) begin
			return CH_LOW;
		end else if (c > CH_HIGH) begin
			return CH_HIGH;
		end
		return c;
	endfunction

	function automatic logic is_ping(input logic [7:0] b);
		logic [7:0] c;
		c = b & CH_MASK;
		return b[7] && (c >= {4'd0, CH_LOW}) && (c <= {4'd0, CH_HIGH});
	endfunction

endpackage

// ----- design/csl_ram.sv -----
module csl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/csl_link.sv -----
module csl_link (
	input  logic                clk,
	input  logic                arst_n,
	input  csl_pkg::link_ctl_t  ctl,
	output csl_pkg::link_stat_t stat
);

	logic [3:0]  channel_q, channel_n;
	logic        scan_q, scan_n;
	logic [3:0]  pending_q, pending_n;
	logic [15:0] hop_q, hop_n;
	logic [15:0] ping_q, ping_n;
	logic [15:0] hop_inc, ping_inc;
	logic [3:0]  ch_hop;
	logic        ping_send;
	logic        locked;

	assign hop_inc  = (hop_q == csl_pkg::SAT16) ? hop_q : hop_q + 16'd1;
	assign ping_inc = (ping_q == csl_pkg::SAT16) ? ping_q : ping_q + 16'd1;

	always_comb begin
		channel_n = channel_q;
		scan_n    = scan_q;
		pending_n = pending_q;
		hop_n     = hop_q;
		ping_n    = ping_q;
		ch_hop    = channel_q;
		ping_send = 1'b0;
		locked    = 1'b0;
		if (ctl.restart) begin
			scan_n    = ctl.scan_enable;
			channel_n = ctl.scan_enable ? csl_pkg::CH_LOW
				: csl_pkg::clamp_channel(ctl.station_channel);
			hop_n     = '0;
			ping_n    = '0;
			pending_n = '0;
		end else if (ctl.tick) begin
			// hop, then ping on the new channel, then pin a heard channel
			if (scan_q) begin
				if (hop_inc >= ctl.dwell_ticks) begin
					hop_n  = '0;
					ch_hop = (channel_q >= csl_pkg::CH_HIGH) ? csl_pkg::CH_LOW
						: channel_q + 4'd1;
				end else begin
					hop_n = hop_inc;
				end
			end
			if (ping_inc >= ctl.ping_ticks) begin
				ping_n    = '0;
				ping_send = 1'b1;
			end else begin
				ping_n = ping_inc;
			end
			channel_n = ch_hop;
			if (pending_q != 4'd0) begin
				channel_n = pending_q;
				pending_n = '0;
				locked    = 1'b1;
			end
		end else if (ctl.lock_req) begin
			pending_n = ctl.lock_channel;
			scan_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= csl_pkg::CH_LOW;
			scan_q    <= 1'b1;
			pending_q <= '0;
			hop_q     <= '0;
			ping_q    <= '0;
		end else begin
			channel_q <= channel_n;
			scan_q    <= scan_n;
			pending_q <= pending_n;
			hop_q     <= hop_n;
			ping_q    <= ping_n;
		end
	end

	assign stat.channel      = channel_q;
	assign stat.scanning     = scan_q;
	assign stat.ping_send    = ping_send;
	assign stat.ping_value   = ping_send ? (csl_pkg::PING_MARK | {4'd0, ch_hop}) : 8'd0;
	assign stat.locked_event = locked;

endmodule

// ----- design/channel_scan_lock_rx_queue_core.sv -----
// Receive controller: channel scan and lock, plus a ring of received frames.
// Input words (s_*) carry one command each: a tick, a received byte (s_tlast
// marks the final byte of a frame), a byte read from the oldest frame, or a
// release of the oldest frame. Every input word gives exactly one result
// word on m_*, holding the tick outcome, the read byte and the ring status.
// The APB port writes scan_enable, station_channel, dwell_ticks and
// ping_ticks; a write to either of the first two restarts the scan.
// Timing: an accepted word is followed by ST_META, which reads the metadata
// memory, and ST_RESP, which loads the result into the output register if
// it is free; no new word is taken until ST_IDLE. The pace is set by the
// one-cycle read latency of the slot metadata memory, which must be read
// back at the updated oldest slot after every word.
// Reset empties the ring at once (head and tail pointers only, the memories
// need no clearing) and starts scanning from channel 1 with default timing.
// When the receiver stalls, the finished result waits in the output
// register; one more word is taken and its result holds until that register
// drains, and further words are not taken meanwhile.
module channel_scan_lock_rx_queue_core #(
	parameter int QUEUE_SLOTS = 8,
	parameter int PAYLOAD_MAX = 250
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// rx_byte[7:0], rx_rssi[15:8], rx_source[63:16], read_index[71:64]
	input  logic [71:0]  s_tdata,
	input  logic         s_tlast,
	// cmd[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// ping_send[0], ping_value[8:1], current_channel[12:9], scanning[13],
	// locked_event[14], read_valid[15], read_data[23:16], frame_length[31:24],
	// frame_rssi[39:32], frame_src[87:40], frames_held[90:88],
	// latest_rssi[98:91], zero[103:99]
	output logic [103:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int PTR_W  = $clog2(QUEUE_SLOTS);
	localparam int CNT_W  = $clog2(PAYLOAD_MAX + 2);
	localparam int LEN_W  = $clog2(PAYLOAD_MAX + 1);
	localparam int META_W = LEN_W + 56;
	localparam int PAY_D  = QUEUE_SLOTS * PAYLOAD_MAX;
	localparam int AW     = $clog2(PAY_D);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	// configuration registers
	logic        scan_en_q, scan_en_n;
	logic [3:0]  station_q, station_n;
	logic [15:0] dwell_q, ping_ticks_q;
	logic        cfg_wr;
	logic        restart;
	csl_pkg::reg_idx_t cfg_idx;

	// input fields
	csl_pkg::cmd_t     cmd;
	logic [7:0]        rx_byte;
	logic signed [7:0] rx_rssi;
	logic [47:0]       rx_source;
	logic [7:0]        read_index;
	logic              acc;

	// ring control
	logic [PTR_W-1:0]  head_q, head_n, tail_q, tail_n, head_next;
	logic [CNT_W-1:0]  cnt_q, cnt_n, cnt_sat;
	logic [7:0]        first_q, first_n;
	logic signed [7:0] rssi_q, rssi_n;
	logic [LEN_W-1:0]  len_store;
	logic              frame_ping;
	logic              rv;
	logic              lock_req;
	logic [3:0]        lock_ch;

	// memories
	logic              pay_we, pay_re;
	logic [AW-1:0]     pay_waddr, pay_raddr;
	logic [7:0]        pay_rdata;
	logic              meta_we, meta_re;
	logic [META_W-1:0] meta_wdata, meta_rdata;
	logic [LEN_W-1:0]  meta_len;
	logic signed [7:0] meta_rssi;
	logic [47:0]       meta_src;

	// sequencer and result
	csl_pkg::seq_state_t state_q, state_n;
	logic                out_load;
	logic                m_tvalid_q;
	logic [103:0]        m_tdata_q;
	logic                ping_send_q, locked_q, rv_q;
	logic [7:0]          ping_value_q;
	logic [PTR_W:0]      held_wide;
	logic [PTR_W+2:0]    held_ext;
	logic [LEN_W+7:0]    len_ext;
	logic                held_nz;

	csl_pkg::link_ctl_t  link_ctl;
	csl_pkg::link_stat_t link_stat;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = csl_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		scan_en_n = scan_en_q;
		station_n = station_q;
		restart   = 1'b0;
		if (cfg_wr) begin
			case (cfg_idx)
				csl_pkg::REG_SCAN_ENABLE: begin
					scan_en_n = pwdata[0];
					restart   = 1'b1;
				end
				csl_pkg::REG_STATION_CHANNEL: begin
					station_n = pwdata[3:0];
					restart   = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_q    <= 1'b1;
			station_q    <= csl_pkg::CH_LOW;
			dwell_q      <= csl_pkg::DWELL_RESET;
			ping_ticks_q <= csl_pkg::PING_RESET;
		end else begin
			scan_en_q <= scan_en_n;
			station_q <= station_n;
			if (cfg_wr && cfg_idx == csl_pkg::REG_DWELL_TICKS) begin
				dwell_q <= pwdata[15:0];
			end
			if (cfg_wr && cfg_idx == csl_pkg::REG_PING_TICKS) begin
				ping_ticks_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		case (cfg_idx)
			csl_pkg::REG_SCAN_ENABLE:     prdata = {31'd0, scan_en_q};
			csl_pkg::REG_STATION_CHANNEL: prdata = {28'd0, station_q};
			csl_pkg::REG_DWELL_TICKS:     prdata = {16'd0, dwell_q};
			csl_pkg::REG_PING_TICKS:      prdata = {16'd0, ping_ticks_q};
			default:                      prdata = '0;
		endcase
	end

	// ---------------- input word ----------------
	assign cmd        = csl_pkg::cmd_t'(s_tuser);
	assign rx_byte    = s_tdata[7:0];
	assign rx_rssi    = s_tdata[15:8];
	assign rx_source  = s_tdata[63:16];
	assign read_index = s_tdata[71:64];
	assign s_tready   = (state_q == csl_pkg::ST_IDLE);
	assign acc        = s_tvalid && s_tready;

	// metadata of the oldest slot, read back after every word
	assign meta_len  = meta_rdata[LEN_W-1:0];
	assign meta_rssi = meta_rdata[LEN_W+7:LEN_W];
	assign meta_src  = meta_rdata[META_W-1:LEN_W+8];

	assign head_next = ptr_inc(head_q);
	assign cnt_sat   = (cnt_q == CNT_W'(PAYLOAD_MAX + 1)) ? cnt_q : cnt_q + CNT_W'(1);
	assign len_store = (cnt_sat > CNT_W'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX)
		: LEN_W'(cnt_sat);
	assign frame_ping = (cnt_q == '0) && csl_pkg::is_ping(rx_byte);

	always_comb begin
		head_n     = head_q;
		tail_n     = tail_q;
		cnt_n      = cnt_q;
		first_n    = first_q;
		rssi_n     = rssi_q;
		pay_we     = 1'b0;
		pay_waddr  = AW'(head_q) * AW'(PAYLOAD_MAX) + AW'(cnt_q);
		pay_re     = 1'b0;
		pay_raddr  = AW'(tail_q) * AW'(PAYLOAD_MAX) + AW'(read_index);
		meta_we    = 1'b0;
		meta_wdata = {rx_source, rx_rssi, len_store};
		rv         = 1'b0;
		lock_req   = 1'b0;
		lock_ch    = first_q[3:0];
		if (acc) begin
			case (cmd)
				csl_pkg::CMD_RX: begin
					if (cnt_q == '0) begin
						first_n = rx_byte;
					end
					pay_we = (cnt_q < CNT_W'(PAYLOAD_MAX));
					cnt_n  = cnt_sat;
					if (s_tlast) begin
						cnt_n  = '0;
						rssi_n = rx_rssi;
						if (link_stat.scanning) begin
							// a heard ping stops the scan, other frames drop
							lock_req = frame_ping;
							lock_ch  = rx_byte[3:0];
						end else if (!frame_ping) begin
							meta_we = 1'b1;
							head_n  = head_next;
							if (head_next == tail_q) begin
								tail_n = ptr_inc(tail_q);
							end
						end
					end
				end
				csl_pkg::CMD_READ: begin
					rv     = (head_q != tail_q)
						&& ({1'b0, read_index} < 9'(meta_len));
					pay_re = rv;
				end
				csl_pkg::CMD_RELEASE: begin
					if (head_q != tail_q) begin
						tail_n = ptr_inc(tail_q);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			first_q <= '0;
			rssi_q  <= csl_pkg::RSSI_RESET;
		end else begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			cnt_q   <= cnt_n;
			first_q <= first_n;
			rssi_q  <= rssi_n;
		end
	end

	// ---------------- link control ----------------
	assign link_ctl.tick            = acc && (cmd == csl_pkg::CMD_TICK);
	assign link_ctl.restart         = restart;
	assign link_ctl.scan_enable     = scan_en_n;
	assign link_ctl.station_channel = station_n;
	assign link_ctl.dwell_ticks     = dwell_q;
	assign link_ctl.ping_ticks      = ping_ticks_q;
	assign link_ctl.lock_req        = lock_req;
	assign link_ctl.lock_channel    = lock_ch;

	csl_link u_link (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (link_ctl),
		.stat   (link_stat)
	);

	csl_ram #(
		.WIDTH (8),
		.DEPTH (PAY_D)
	) u_payload_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (rx_byte),
		.re    (pay_re),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

	csl_ram #(
		.WIDTH (META_W),
		.DEPTH (QUEUE_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (head_q),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (tail_q),
		.rdata (meta_rdata)
	);

	// ---------------- sequencer ----------------
	always_comb begin
		state_n = state_q;
		case (state_q)
			csl_pkg::ST_IDLE: begin
				if (acc) begin
					state_n = csl_pkg::ST_META;
				end
			end
			csl_pkg::ST_META: state_n = csl_pkg::ST_RESP;
			csl_pkg::ST_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					state_n = csl_pkg::ST_IDLE;
				end
			end
			default: state_n = csl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		meta_re  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			csl_pkg::ST_META: meta_re = 1'b1;
			csl_pkg::ST_RESP: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= csl_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// hold the per-word outcome until the status is read back
	always_ff @(posedge clk) begin
		if (acc) begin
			ping_send_q  <= link_stat.ping_send;
			ping_value_q <= link_stat.ping_value;
			locked_q     <= link_stat.locked_event;
			rv_q         <= rv;
		end
	end

	assign held_wide = (head_q >= tail_q) ? {1'b0, head_q} - {1'b0, tail_q}
		: {1'b0, head_q} + (PTR_W + 1)'(QUEUE_SLOTS) - {1'b0, tail_q};
	assign held_ext  = {2'b00, held_wide};
	assign held_nz   = (head_q != tail_q);
	assign len_ext   = {8'd0, meta_len};

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {
				5'd0,
				rssi_q,
				held_ext[2:0],
				held_nz ? meta_src : 48'd0,
				held_nz ? meta_rssi : 8'sd0,
				held_nz ? len_ext[7:0] : 8'd0,
				rv_q ? pay_rdata : 8'd0,
				rv_q,
				locked_q,
				link_stat.scanning,
				link_stat.channel,
				ping_value_q,
				ping_send_q
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
